// File: rtl/icfct_pkg.sv
// Package for the I2C commanded fault countdown timer.
// Types, codes and frame constants shared by icfct_link and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package icfct_pkg;

  localparam int RX_FRAME_BYTES = 6;
  localparam int TX_FRAME_BYTES = 6;
  localparam int CNT_W          = $clog2(RX_FRAME_BYTES + 1);
  localparam int IDX_W          = $clog2(TX_FRAME_BYTES);

  localparam logic [7:0]  SUM_OK   = 8'hFF;
  localparam logic [31:0] CNT_ONES = 32'hFFFF_FFFF;

  localparam logic [7:0] SET_CODE_RST   = 8'd1;
  localparam logic [7:0] STOP_CODE_RST  = 8'd2;
  localparam logic [7:0] CLEAR_CODE_RST = 8'd3;

  typedef enum logic [1:0] {
    CFG_SET   = 2'd0,
    CFG_STOP  = 2'd1,
    CFG_CLEAR = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_CLEARED = 2'd0,
    MODE_PAUSED  = 2'd1,
    MODE_RUNNING = 2'd2,
    MODE_ELAPSED = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_RX    = 2'd2,
    ACT_TX    = 2'd3
  } act_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       start_pin_high;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        fault_n;
    logic        led_level;
    logic [1:0]  timer_status;
    logic [31:0] count_value;
  } out_word_t;

  // frame completion event from the bus side to the timer
  typedef struct packed {
    logic        done;
    logic        ok;
    logic [7:0]  msg_type;
    logic [31:0] value;
  } frame_t;

endpackage

`default_nettype wire

// File: rtl/icfct_link.sv
// Bus side of the timer: receive frame assembly with running checksum,
// reply snapshot and transmit byte pointer. Uses icfct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module icfct_link
  import icfct_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  data_byte,
  input  wire logic [31:0] count,
  input  wire mode_t       mode,
  output frame_t           frame,
  output logic [7:0]       tx_byte
);

  // first five bytes; the sixth is the byte that completes the frame
  logic [7:0]       rx_frame [0:RX_FRAME_BYTES-2];
  logic [CNT_W-1:0] rx_count;
  logic [7:0]       rx_sum;
  logic [7:0]       rx_sum_next;

  // reply snapshot
  logic [31:0]      tx_count;
  logic [1:0]       tx_mode;
  logic [7:0]       tx_csum;
  logic [7:0]       snap_csum;
  logic [IDX_W-1:0] tx_index;

  logic is_rx;
  logic is_tx;
  logic store;

  assign is_rx       = step && (action == ACT_RX);
  assign is_tx       = step && (action == ACT_TX);
  assign store       = is_rx && (rx_count < CNT_W'(RX_FRAME_BYTES));
  assign rx_sum_next = rx_sum + data_byte;

  assign frame.done     = store && (rx_count == CNT_W'(RX_FRAME_BYTES - 1));
  assign frame.ok       = (rx_sum_next == SUM_OK);
  assign frame.msg_type = rx_frame[0];
  assign frame.value    = {rx_frame[4], rx_frame[3], rx_frame[2], rx_frame[1]};

  assign snap_csum = SUM_OK - (count[7:0] + count[15:8] + count[23:16] + count[31:24]
                               + {6'd0, mode});

  always_comb begin
    case (tx_index)
      IDX_W'(0): tx_byte = tx_count[7:0];
      IDX_W'(1): tx_byte = tx_count[15:8];
      IDX_W'(2): tx_byte = tx_count[23:16];
      IDX_W'(3): tx_byte = tx_count[31:24];
      IDX_W'(4): tx_byte = {6'd0, tx_mode};
      default:   tx_byte = tx_csum;
    endcase
  end

  always_ff @(posedge clk) begin
    if (store && (rx_count < CNT_W'(RX_FRAME_BYTES - 1))) begin
      rx_frame[rx_count] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count <= '0;
      rx_sum   <= '0;
      tx_index <= '0;
      tx_count <= '0;
      tx_mode  <= '0;
      tx_csum  <= SUM_OK;
    end else begin
      if (is_rx) begin
        tx_index <= '0;
      end
      if (store) begin
        rx_count <= rx_count + CNT_W'(1);
        rx_sum   <= rx_sum_next;
      end
      if (frame.done) begin
        tx_count <= count;
        tx_mode  <= mode;
        tx_csum  <= snap_csum;
      end
      if (is_tx) begin
        rx_count <= '0;
        rx_sum   <= '0;
        tx_index <= (tx_index == IDX_W'(TX_FRAME_BYTES - 1)) ? '0 : tx_index + IDX_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/i2c_commanded_fault_countdown_timer.sv
// Countdown fault timer driven by a word stream of ticks, start pin edges,
// received bus bytes and transmit byte requests. One word is taken per cycle;
// its result appears in the output register on the next cycle. in_ready drops
// only while that output register holds a result that is not being taken, so
// with out_ready high the block sustains one word per clock.
// Depends on icfct_pkg and icfct_link.
`timescale 1ns / 1ps
`default_nettype none

module i2c_commanded_fault_countdown_timer
  import icfct_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  logic [7:0] set_code;
  logic [7:0] stop_code;
  logic [7:0] clear_code;

  mode_t       mode;
  mode_t       mode_next;
  logic [31:0] count;
  logic [31:0] count_next;
  logic        counting;
  logic        counting_next;
  logic        fault_level;
  logic        fault_level_next;
  logic        led;
  logic        led_next;

  logic       accept;
  frame_t     frame;
  logic [7:0] link_tx_byte;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  icfct_link u_link (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .action    (in_data.action),
    .data_byte (in_data.data_byte),
    .count     (count),
    .mode      (mode),
    .frame     (frame),
    .tx_byte   (link_tx_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      set_code   <= SET_CODE_RST;
      stop_code  <= STOP_CODE_RST;
      clear_code <= CLEAR_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET:   set_code   <= cfg_data;
        CFG_STOP:  stop_code  <= cfg_data;
        CFG_CLEAR: clear_code <= cfg_data;
        default:   ;
      endcase
    end
  end

  always_comb begin
    mode_next        = mode;
    count_next       = count;
    counting_next    = counting;
    fault_level_next = fault_level;
    led_next         = led;
    case (in_data.action)
      ACT_TICK: begin
        if (counting) begin
          if (count == '0) begin
            count_next    = CNT_ONES;
            counting_next = 1'b0;
            if (mode == MODE_RUNNING) begin
              mode_next        = MODE_ELAPSED;
              fault_level_next = 1'b0;
            end
          end else begin
            count_next = count - 32'd1;
          end
        end
      end
      ACT_START: begin
        if (mode == MODE_PAUSED) begin
          led_next      = 1'b0;
          counting_next = 1'b1;
          mode_next     = MODE_RUNNING;
        end
      end
      ACT_RX: begin
        // first match wins: set, then stop, then clear
        if (frame.done && frame.ok) begin
          if (frame.msg_type == set_code) begin
            if (mode inside {MODE_PAUSED, MODE_CLEARED}) begin
              mode_next  = MODE_PAUSED;
              count_next = frame.value;
            end
          end else if (frame.msg_type == stop_code) begin
            if (in_data.start_pin_high) begin
              led_next      = 1'b1;
              mode_next     = MODE_PAUSED;
              counting_next = 1'b0;
            end
          end else if (frame.msg_type == clear_code) begin
            if (mode != MODE_RUNNING) begin
              mode_next        = MODE_CLEARED;
              count_next       = CNT_ONES;
              fault_level_next = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_CLEARED;
      count       <= '0;
      counting    <= 1'b0;
      fault_level <= 1'b1;
      led         <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        mode        <= mode_next;
        count       <= count_next;
        counting    <= counting_next;
        fault_level <= fault_level_next;
        led         <= led_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.tx_byte      <= (in_data.action == ACT_TX) ? link_tx_byte : 8'd0;
      out_data.fault_n      <= fault_level_next;
      out_data.led_level    <= led_next;
      out_data.timer_status <= mode_next;
      out_data.count_value  <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_counting_iff_running: assert property (@(posedge clk) disable iff (rst)
    counting == (mode == MODE_RUNNING))
    else $error("counting flag disagrees with running mode");

  a_tick_decrements: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.action == ACT_TICK && counting && count != '0)
      |=> count == $past(count) - 32'd1)
    else $error("tick did not decrement the count");

  a_fault_only_on_elapse: assert property (@(posedge clk) disable iff (rst)
    $fell(fault_level) |-> mode == MODE_ELAPSED)
    else $error("fault asserted without elapse");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    $past(accept) |-> (out_data.count_value == count && out_data.timer_status == mode))
    else $error("result register out of step with timer state");
`endif

endmodule

`default_nettype wire

// File: bench/fault_timer_checker.sv
// Checker for the commanded fault countdown timer: watches both word channels and
// the register port, keeps its own copy of the timer, and compares every result word.
// Depends on icfct_pkg.
`timescale 1ns / 1ps

module fault_timer_checker
  import icfct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_word_t   in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_word_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         pending,
  output int         fails
);

  logic [7:0]  set_code, stop_code, clear_code;
  mode_t       mode;
  logic [31:0] count;
  logic        counting;
  logic        fault_level;
  logic        led;
  logic [7:0]  rx_frame [RX_FRAME_BYTES];
  logic [2:0]  rx_count;
  logic [7:0]  rx_sum;
  logic [7:0]  tx_frame [TX_FRAME_BYTES];
  logic [2:0]  tx_index;

  out_word_t   expected_words [$];
  out_word_t   want, got_next;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] exp_val);
    $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, exp_val);
    fails = fails + 1;
  endtask

  task automatic advance_timer(input in_word_t w, output out_word_t r);
    logic [7:0] sum;
    logic [7:0] txb;
    logic [7:0] kind;
    txb = 8'h00;
    case (act_t'(w.action))
      ACT_TICK: begin
        if (counting) begin
          if (count == 32'd0) begin
            count = CNT_ONES;
            counting = 1'b0;
            if (mode == MODE_RUNNING) begin
              mode = MODE_ELAPSED;
              fault_level = 1'b0;
            end
          end else begin
            count = count - 32'd1;
          end
        end
      end
      ACT_START: begin
        if (mode == MODE_PAUSED) begin
          led = 1'b0;
          counting = 1'b1;
          mode = MODE_RUNNING;
        end
      end
      ACT_RX: begin
        tx_index = '0;
        if (rx_count < RX_FRAME_BYTES) begin
          rx_frame[rx_count] = w.data_byte;
          rx_sum = rx_sum + w.data_byte;
          rx_count = rx_count + 3'd1;
          if (rx_count == RX_FRAME_BYTES) begin
            // reply holds the state from before the message acts
            tx_frame[0] = count[7:0];
            tx_frame[1] = count[15:8];
            tx_frame[2] = count[23:16];
            tx_frame[3] = count[31:24];
            tx_frame[4] = {6'b0, mode};
            sum = 8'h00;
            for (int i = 0; i < TX_FRAME_BYTES - 1; i++) sum = sum + tx_frame[i];
            tx_frame[TX_FRAME_BYTES - 1] = SUM_OK - sum;
            kind = rx_frame[0];
            if (rx_sum == SUM_OK) begin
              // first match wins when codes are equal
              if (kind == set_code) begin
                if (mode == MODE_PAUSED || mode == MODE_CLEARED) begin
                  mode = MODE_PAUSED;
                  count = {rx_frame[4], rx_frame[3], rx_frame[2], rx_frame[1]};
                end
              end else if (kind == stop_code) begin
                if (w.start_pin_high) begin
                  led = 1'b1;
                  mode = MODE_PAUSED;
                  counting = 1'b0;
                end
              end else if (kind == clear_code) begin
                if (mode != MODE_RUNNING) begin
                  mode = MODE_CLEARED;
                  count = CNT_ONES;
                  fault_level = 1'b1;
                end
              end
            end
          end
        end
      end
      default: begin
        rx_count = '0;
        rx_sum = 8'h00;
        if (tx_index >= TX_FRAME_BYTES) tx_index = '0;
        txb = tx_frame[tx_index];
        tx_index = (tx_index == TX_FRAME_BYTES - 1) ? 3'd0 : tx_index + 3'd1;
      end
    endcase
    r.tx_byte      = txb;
    r.fault_n      = fault_level;
    r.led_level    = led;
    r.timer_status = mode;
    r.count_value  = count;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      set_code    = SET_CODE_RST;
      stop_code   = STOP_CODE_RST;
      clear_code  = CLEAR_CODE_RST;
      mode        = MODE_CLEARED;
      count       = 32'd0;
      counting    = 1'b0;
      fault_level = 1'b1;
      led         = 1'b1;
      rx_count    = '0;
      rx_sum      = 8'h00;
      tx_index    = '0;
      for (int i = 0; i < TX_FRAME_BYTES; i++) tx_frame[i] = 8'h00;
      tx_frame[TX_FRAME_BYTES - 1] = SUM_OK;
      expected_words.delete();
      fails = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SET:   set_code   = cfg_data;
          CFG_STOP:  stop_code  = cfg_data;
          CFG_CLEAR: clear_code = cfg_data;
          default: ;
        endcase
      end
      // results leave before the word taken at this edge can produce one
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          flag_mismatch("word with nothing expected", out_data.count_value, 32'd0);
        end else begin
          want = expected_words.pop_front();
          if (out_data.tx_byte !== want.tx_byte)
            flag_mismatch("tx_byte", out_data.tx_byte, want.tx_byte);
          if (out_data.fault_n !== want.fault_n)
            flag_mismatch("fault_n", out_data.fault_n, want.fault_n);
          if (out_data.led_level !== want.led_level)
            flag_mismatch("led_level", out_data.led_level, want.led_level);
          if (out_data.timer_status !== want.timer_status)
            flag_mismatch("timer_status", out_data.timer_status, want.timer_status);
          if (out_data.count_value !== want.count_value)
            flag_mismatch("count_value", out_data.count_value, want.count_value);
        end
      end
      if (in_valid && in_ready) begin
        advance_timer(in_data, got_next);
        expected_words.push_back(got_next);
      end
    end
    pending <= expected_words.size();
  end

endmodule

// File: bench/i2c_commanded_fault_countdown_timer_test.sv
// Top of the bench for the commanded fault countdown timer: clock, reset, word
// stimulus, register writes, receiver stalls, watchdog and verdict.
// Depends on icfct_pkg, the block itself and fault_timer_checker.
`timescale 1ns / 1ps

module i2c_commanded_fault_countdown_timer_test;
  import icfct_pkg::*;

  localparam int IDLE_LIMIT = 1000;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  in_word_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_word_t  out_data;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  int         pending;
  int         fails;

  logic [7:0] cur_set, cur_stop, cur_clear;
  bit         calm;
  bit         pressure_on;
  int         sent;
  int         steady_left;
  int         idle_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  i2c_commanded_fault_countdown_timer u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fault_timer_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .fails     (fails)
  );

  // receiver: random stall bursts, one long hold when asked, none at the end
  initial begin
    int stall_left, run_left, hold_left;
    bit held;
    stall_left = 0;
    run_left = 0;
    hold_left = 0;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (pressure_on && !held) begin
        held = 1'b1;
        hold_left = 79;
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left = $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 8);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic in_word_t word_of(input act_t a, input logic [7:0] d, input logic p);
    in_word_t w;
    w.action = a;
    w.data_byte = d;
    w.start_pin_high = p;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    if (!calm) begin
      if (steady_left > 0) begin
        steady_left--;
      end else begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        steady_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 5);
      end
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_frame(input logic [7:0] kind, input logic [31:0] value,
                            input bit good, input logic pin);
    logic [7:0] b [RX_FRAME_BYTES];
    logic [7:0] s;
    b[0] = kind;
    b[1] = value[7:0];
    b[2] = value[15:8];
    b[3] = value[23:16];
    b[4] = value[31:24];
    s = b[0] + b[1] + b[2] + b[3] + b[4];
    b[5] = SUM_OK - s;
    if (!good) b[5] = b[5] + 8'($urandom_range(1, 255));
    for (int i = 0; i < RX_FRAME_BYTES; i++)
      send_word(word_of(ACT_RX, b[i], (i == RX_FRAME_BYTES - 1) ? pin : 1'($urandom_range(0, 1))));
  endtask

  task automatic read_reply(input int n);
    repeat (n) send_word(word_of(ACT_TX, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(word_of(ACT_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SET:   cur_set = v;
      CFG_STOP:  cur_stop = v;
      CFG_CLEAR: cur_clear = v;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return CNT_ONES;
      2: return $urandom;
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 5))
      0, 1: return cur_set;
      2: return cur_stop;
      3: return cur_clear;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic run_phase(input int items);
    int target, pick;
    target = sent + items;
    while (sent < target) begin
      pick = $urandom_range(0, 19);
      if (pick < 9) begin
        // re-arm, full frame, then read some of the reply
        read_reply(1);
        send_frame(pick_type(), pick_value(), $urandom_range(0, 9) != 0,
                   $urandom_range(0, 4) != 0);
        read_reply($urandom_range(0, 8));
      end else if (pick < 12) begin
        send_word(word_of(ACT_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
      end else if (pick < 17) begin
        send_ticks($urandom_range(1, 30));
      end else if (pick < 19) begin
        repeat ($urandom_range(1, 8))
          send_word(word_of(act_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1))));
      end else begin
        // short or overlong frame
        read_reply(1);
        repeat ($urandom_range(0, 1) ? $urandom_range(1, 5) : $urandom_range(7, 10))
          send_word(word_of(ACT_RX, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_SET;
    cfg_data = 8'h00;
    calm = 1'b0;
    pressure_on = 1'b0;
    sent = 0;
    steady_left = 0;
    cur_set = SET_CODE_RST;
    cur_stop = STOP_CODE_RST;
    cur_clear = CLEAR_CODE_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle tick and start, load, run out, read reply, clear the fault
    send_ticks(1);
    send_word(word_of(ACT_START, 8'hFF, 1'b0));
    send_frame(SET_CODE_RST, 32'd3, 1'b1, 1'b1);
    send_word(word_of(ACT_START, 8'h00, 1'b1));
    send_ticks(5);
    read_reply(6);
    send_frame(CLEAR_CODE_RST, 32'hFFFF_FFFF, 1'b1, 1'b0);
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        1: begin
          write_reg(CFG_SET, 8'h00);
          write_reg(CFG_STOP, 8'hFF);
          write_reg(CFG_CLEAR, 8'h80);
        end
        2: begin
          write_reg(CFG_SET, 8'hFF);
          write_reg(CFG_STOP, 8'h00);
          write_reg(CFG_CLEAR, 8'h01);
          pressure_on = 1'b1;
        end
        3: begin
          write_reg(CFG_SET, 8'h5A);
          write_reg(CFG_STOP, 8'h5A);
          write_reg(CFG_CLEAR, 8'h5A);
          write_reg(CFG_NONE, 8'($urandom_range(0, 255)));
        end
        4: begin
          write_reg(CFG_SET, 8'($urandom_range(0, 255)));
          write_reg(CFG_STOP, 8'($urandom_range(0, 255)));
          write_reg(CFG_CLEAR, 8'($urandom_range(0, 255)));
        end
        5: begin
          write_reg(CFG_SET, 8'h07);
          write_reg(CFG_STOP, 8'h09);
          write_reg(CFG_CLEAR, 8'h07);
        end
        6: begin
          write_reg(CFG_SET, 8'h01);
          write_reg(CFG_STOP, 8'h04);
          write_reg(CFG_CLEAR, 8'h04);
        end
        7: begin
          write_reg(CFG_SET, SET_CODE_RST);
          write_reg(CFG_STOP, STOP_CODE_RST);
          write_reg(CFG_CLEAR, CLEAR_CODE_RST);
          calm = 1'b1;
        end
        default: ;
      endcase
      run_phase(150);
      settle();
    end

    repeat (5) @(posedge clk);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
